// ===== src/iets_pkg.sv =====
// Shared types and constants for the serial EEPROM transaction sequencer.
// Used by the front, queue, back and top-level modules.
`default_nettype none
package iets_pkg;

	// Write page size in bytes; must be a power of two
	localparam int PAGE_BYTES = 64;
	localparam logic [15:0] PAGE_MASK = 16'(PAGE_BYTES - 1);

	// Request modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Bus symbols
	localparam logic [2:0] SYM_START     = 3'd0;
	localparam logic [2:0] SYM_STOP      = 3'd1;
	localparam logic [2:0] SYM_SEND      = 3'd2;
	localparam logic [2:0] SYM_RECV_ACK  = 3'd3;
	localparam logic [2:0] SYM_RECV_NACK = 3'd4;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd80;
	localparam logic [7:0] CLEAR_BYTE     = 8'hFF;

	// Config port: one register, word index taken from paddr[2]
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_DEVICE_ADDRESS = 1'b0;

	// Plan queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Symbol slots walked by the back end, in bus order
	localparam int NUM_SLOTS = 9;
	localparam int SLOT_W = $clog2(NUM_SLOTS + 1);
	localparam logic [SLOT_W-1:0] SLOT_PRE_STOP  = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_START     = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_WR_SEL    = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_ADDR_HI   = SLOT_W'(3);
	localparam logic [SLOT_W-1:0] SLOT_ADDR_LO   = SLOT_W'(4);
	localparam logic [SLOT_W-1:0] SLOT_RESTART   = SLOT_W'(5);
	localparam logic [SLOT_W-1:0] SLOT_RD_SEL    = SLOT_W'(6);
	localparam logic [SLOT_W-1:0] SLOT_BODY      = SLOT_W'(7);
	localparam logic [SLOT_W-1:0] SLOT_POST_STOP = SLOT_W'(8);

	// Everything the back end needs to play out one request
	typedef struct packed {
		logic        pre_stop;
		logic        hdr;
		logic        hdr_rd;
		logic [15:0] hdr_addr;
		logic [6:0]  sel;
		logic [2:0]  body_sym;
		logic [7:0]  body_byte;
		logic        post_stop;
	} plan_t;

endpackage
`default_nettype wire

// ===== src/iets_if.sv =====
// Valid/ready channel interfaces for requests and bus symbols.
// Depends on nothing but plain logic types.
`default_nettype none
interface iets_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] address;
	logic [7:0]  data;
	logic        first;
	logic        last;

	modport source (output valid, mode, address, data, first, last, input ready);
	modport sink (input valid, mode, address, data, first, last, output ready);
endinterface

interface iets_sym_if;
	logic       valid;
	logic       ready;
	logic [2:0] symbol;
	logic [7:0] byte_value;
	logic       end_of_run;

	modport source (output valid, symbol, byte_value, end_of_run, input ready);
	modport sink (input valid, symbol, byte_value, end_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/iets_front.sv =====
// Front end: accepts requests, tracks burst and address state, builds a plan.
// Depends on iets_pkg and iets_req_if.
`default_nettype none
module iets_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	iets_req_if.sink          req,
	input  wire logic [6:0]   dev_addr,
	input  wire logic         q_full,
	output logic              push,
	output iets_pkg::plan_t   plan
);

	logic [15:0] run_addr_q;
	logic        open_q;
	logic        open_rd_q;

	logic        is_read;
	logic [15:0] base_addr;
	logic        split;

	assign req.ready = !q_full;
	assign is_read = (req.mode == iets_pkg::MODE_READ);

	always_comb begin
		base_addr = req.first ? req.address : run_addr_q;
		split = 1'b0;
		if (!req.first) begin
			if (open_rd_q != is_read) begin
				split = 1'b1;
			end else if (!is_read && ((run_addr_q & iets_pkg::PAGE_MASK) == 16'd0)) begin
				split = 1'b1;
			end
		end

		plan.pre_stop  = req.first ? open_q : split;
		plan.hdr       = req.first || split;
		plan.hdr_rd    = is_read;
		plan.hdr_addr  = base_addr;
		plan.sel       = dev_addr;
		plan.post_stop = req.last;
		if (is_read) begin
			plan.body_sym  = req.last ? iets_pkg::SYM_RECV_NACK : iets_pkg::SYM_RECV_ACK;
			plan.body_byte = 8'd0;
		end else begin
			plan.body_sym  = iets_pkg::SYM_SEND;
			plan.body_byte = (req.mode == iets_pkg::MODE_WRITE) ? req.data
				: iets_pkg::CLEAR_BYTE;
		end
	end

	// a continuation with no open burst is accepted and dropped
	assign push = req.valid && req.ready && (req.first || open_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_addr_q <= 16'd0;
			open_q     <= 1'b0;
			open_rd_q  <= 1'b0;
		end else if (push) begin
			run_addr_q <= base_addr + 16'd1;
			open_q     <= !req.last;
			open_rd_q  <= req.last ? 1'b0 : is_read;
		end
	end

endmodule
`default_nettype wire

// ===== src/iets_queue.sv =====
// Short plan queue between the front and back ends.
// Depends on iets_pkg.
`default_nettype none
module iets_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire iets_pkg::plan_t  wr_plan,
	input  wire logic             pop,
	output logic                  full,
	output logic                  head_valid,
	output iets_pkg::plan_t       head
);

	iets_pkg::plan_t entries_q [iets_pkg::QUEUE_DEPTH];
	logic [iets_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [iets_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [iets_pkg::QCNT_W-1:0] count_q;

	assign full       = (count_q == iets_pkg::QCNT_W'(iets_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + iets_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + iets_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + iets_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - iets_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/iets_back.sv =====
// Back end: walks the head plan's slots, one symbol per cycle unless the sink
// stalls, into a registered output. Depends on iets_pkg and iets_sym_if.
`default_nettype none
module iets_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire iets_pkg::plan_t  head,
	output logic                  pop,
	iets_sym_if.source            sym
);

	logic [iets_pkg::SLOT_W-1:0] step_q;
	logic                        valid_q;
	logic [2:0]                  symbol_q;
	logic [7:0]                  byte_q;
	logic                        eor_q;

	logic [iets_pkg::NUM_SLOTS-1:0] en;
	logic [iets_pkg::NUM_SLOTS-1:0] avail;
	logic [iets_pkg::SLOT_W-1:0]    cur;
	logic                           last_slot;
	logic [2:0]                     cur_sym;
	logic [7:0]                     cur_byte;
	logic                           load;

	always_comb begin
		en = '0;
		en[iets_pkg::SLOT_PRE_STOP]  = head.pre_stop;
		en[iets_pkg::SLOT_START]     = head.hdr;
		en[iets_pkg::SLOT_WR_SEL]    = head.hdr;
		en[iets_pkg::SLOT_ADDR_HI]   = head.hdr;
		en[iets_pkg::SLOT_ADDR_LO]   = head.hdr;
		en[iets_pkg::SLOT_RESTART]   = head.hdr && head.hdr_rd;
		en[iets_pkg::SLOT_RD_SEL]    = head.hdr && head.hdr_rd;
		en[iets_pkg::SLOT_BODY]      = 1'b1;
		en[iets_pkg::SLOT_POST_STOP] = head.post_stop;
	end

	// lowest enabled slot at or after the step pointer
	always_comb begin
		for (int i = 0; i < iets_pkg::NUM_SLOTS; i++) begin
			avail[i] = en[i] && (iets_pkg::SLOT_W'(i) >= step_q);
		end
		cur = iets_pkg::SLOT_BODY;
		for (int i = iets_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				cur = iets_pkg::SLOT_W'(i);
			end
		end
		last_slot = 1'b1;
		for (int i = 0; i < iets_pkg::NUM_SLOTS; i++) begin
			if (avail[i] && (iets_pkg::SLOT_W'(i) > cur)) begin
				last_slot = 1'b0;
			end
		end
	end

	always_comb begin
		cur_sym  = iets_pkg::SYM_SEND;
		cur_byte = 8'd0;
		case (cur)
			iets_pkg::SLOT_PRE_STOP:  cur_sym = iets_pkg::SYM_STOP;
			iets_pkg::SLOT_START:     cur_sym = iets_pkg::SYM_START;
			iets_pkg::SLOT_WR_SEL:    cur_byte = {head.sel, 1'b0};
			iets_pkg::SLOT_ADDR_HI:   cur_byte = head.hdr_addr[15:8];
			iets_pkg::SLOT_ADDR_LO:   cur_byte = head.hdr_addr[7:0];
			iets_pkg::SLOT_RESTART:   cur_sym = iets_pkg::SYM_START;
			iets_pkg::SLOT_RD_SEL:    cur_byte = {head.sel, 1'b1};
			iets_pkg::SLOT_BODY: begin
				cur_sym  = head.body_sym;
				cur_byte = (head.body_sym == iets_pkg::SYM_SEND) ? head.body_byte : 8'd0;
			end
			iets_pkg::SLOT_POST_STOP: cur_sym = iets_pkg::SYM_STOP;
			default:                  cur_sym = iets_pkg::SYM_STOP;
		endcase
	end

	assign load = head_valid && (!valid_q || sym.ready);
	assign pop  = load && last_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q  <= last_slot ? '0 : cur + iets_pkg::SLOT_W'(1);
				valid_q <= 1'b1;
			end else if (sym.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			symbol_q <= cur_sym;
			byte_q   <= cur_byte;
			eor_q    <= last_slot;
		end
	end

	assign sym.valid      = valid_q;
	assign sym.symbol     = symbol_q;
	assign sym.byte_value = byte_q;
	assign sym.end_of_run = eor_q;

endmodule
`default_nettype wire

// ===== src/i2c_eeprom_transaction_sequencer.sv =====
// Serial EEPROM transaction sequencer: byte requests in, bus symbols out.
// A request's first symbol passes the plan queue, then the back end's output
// register. One symbol per cycle while the sink is ready; a request plays out
// as 1 to 9 symbols. A 4-entry plan queue lets the front take a request every
// cycle until it fills.
// Reset (arst_n low): burst closed, address 0, queue empty, device address 80.
`default_nettype none
module i2c_eeprom_transaction_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	iets_req_if.sink                           req,
	iets_sym_if.source                         sym,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [iets_pkg::APB_AW-1:0]   paddr,
	input  wire logic [iets_pkg::APB_DW-1:0]   pwdata,
	output logic [iets_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);

	logic [6:0]      dev_addr_q;
	logic            q_full;
	logic            push;
	logic            pop;
	logic            head_valid;
	iets_pkg::plan_t plan;
	iets_pkg::plan_t head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == iets_pkg::REG_DEVICE_ADDRESS)
		? iets_pkg::APB_DW'(dev_addr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= iets_pkg::DEV_ADDR_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == iets_pkg::REG_DEVICE_ADDRESS)) begin
			dev_addr_q <= pwdata[6:0];
		end
	end

	iets_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.dev_addr (dev_addr_q),
		.q_full   (q_full),
		.push     (push),
		.plan     (plan)
	);

	iets_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_plan    (plan),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	iets_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.sym        (sym)
	);

	// a full queue must hold off the front
	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_full))
		else $error("plan pushed into a full queue");

	// the back end only retires a plan it holds
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("plan popped from an empty queue");

	// a nack is always followed by stop within the same request
	assert property (@(posedge clk) disable iff (!arst_n)
		(sym.valid && sym.symbol == iets_pkg::SYM_RECV_NACK) |-> !sym.end_of_run)
		else $error("nack ended a request without stop");

	// a start always opens a header, never ends a request
	assert property (@(posedge clk) disable iff (!arst_n)
		(sym.valid && sym.symbol == iets_pkg::SYM_START) |-> !sym.end_of_run)
		else $error("start ended a request");

endmodule
`default_nettype wire

// ===== bench/iets_symbol_checker.sv =====
`timescale 1ns / 1ps
// Symbol checker for the serial EEPROM transaction sequencer: predicts the bus
// symbols of every accepted request and compares them with the symbol channel.
// Depends on iets_pkg and the request and symbol interfaces.
module iets_symbol_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	iets_req_if                         req,
	iets_sym_if                         sym,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [iets_pkg::APB_AW-1:0] paddr,
	input  logic [iets_pkg::APB_DW-1:0] pwdata,
	output int                          mismatches,
	output int                          outstanding
);
	import iets_pkg::*;

	typedef struct packed {
		logic [2:0] symbol;
		logic [7:0] byte_value;
		logic       end_of_run;
	} bus_symbol_t;

	bus_symbol_t expected_symbols[$];
	bus_symbol_t want;
	logic [6:0]  dev_addr;
	logic [15:0] next_addr;
	logic        burst_open;
	logic        burst_rd;
	int          sym_count;

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp_val);
		mismatches++;
		if (mismatches <= 20)
			$display("%0t: symbol %0d %s: got %0h, want %0h", $time, sym_count, what, got,
				exp_val);
	endtask

	function automatic bus_symbol_t bus_sym(input logic [2:0] s, input logic [7:0] b);
		bus_symbol_t r;
		r.symbol = s;
		r.byte_value = (s == SYM_SEND) ? b : 8'h00;
		r.end_of_run = 1'b0;
		return r;
	endfunction

	task automatic open_header(input logic rd);
		expected_symbols.push_back(bus_sym(SYM_START, 8'h00));
		expected_symbols.push_back(bus_sym(SYM_SEND, {dev_addr, 1'b0}));
		expected_symbols.push_back(bus_sym(SYM_SEND, next_addr[15:8]));
		expected_symbols.push_back(bus_sym(SYM_SEND, next_addr[7:0]));
		if (rd) begin
			expected_symbols.push_back(bus_sym(SYM_START, 8'h00));
			expected_symbols.push_back(bus_sym(SYM_SEND, {dev_addr, 1'b1}));
		end
		burst_open = 1'b1;
		burst_rd = rd;
	endtask

	task automatic predict_symbols(input logic [1:0] mode, input logic [15:0] address,
			input logic [7:0] data, input logic first, input logic last);
		logic rd;
		rd = (mode == MODE_READ);
		if (first) begin
			if (burst_open)
				expected_symbols.push_back(bus_sym(SYM_STOP, 8'h00));
			next_addr = address;
			open_header(rd);
		end else if (!burst_open) begin
			// continuation with nothing open: dropped silently
			return;
		end else if (burst_rd != rd) begin
			expected_symbols.push_back(bus_sym(SYM_STOP, 8'h00));
			open_header(rd);
		end else if (!rd && (next_addr & PAGE_MASK) == 16'h0000) begin
			expected_symbols.push_back(bus_sym(SYM_STOP, 8'h00));
			open_header(1'b0);
		end
		if (rd)
			expected_symbols.push_back(bus_sym(last ? SYM_RECV_NACK : SYM_RECV_ACK, 8'h00));
		else
			expected_symbols.push_back(bus_sym(SYM_SEND,
				(mode == MODE_WRITE) ? data : CLEAR_BYTE));
		next_addr = next_addr + 16'd1;
		if (last) begin
			expected_symbols.push_back(bus_sym(SYM_STOP, 8'h00));
			burst_open = 1'b0;
			burst_rd = 1'b0;
		end
		expected_symbols[expected_symbols.size() - 1].end_of_run = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr = DEV_ADDR_RESET;
			next_addr = 16'h0000;
			burst_open = 1'b0;
			burst_rd = 1'b0;
			sym_count = 0;
			expected_symbols.delete();
			outstanding <= 0;
		end else begin
			// symbols leaving now belong to earlier requests, so pop before predicting
			if (sym.valid && sym.ready) begin
				if (expected_symbols.size() == 0) begin
					report("unexpected", 8'(sym.symbol), 8'h00);
				end else begin
					want = expected_symbols.pop_front();
					if (sym.symbol !== want.symbol)
						report("symbol", 8'(sym.symbol), 8'(want.symbol));
					if (sym.byte_value !== want.byte_value)
						report("byte_value", sym.byte_value, want.byte_value);
					if (sym.end_of_run !== want.end_of_run)
						report("end_of_run", 8'(sym.end_of_run), 8'(want.end_of_run));
				end
				sym_count++;
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_DEVICE_ADDRESS)
				dev_addr = pwdata[6:0];
			if (req.valid && req.ready)
				predict_symbols(req.mode, req.address, req.data, req.first, req.last);
			outstanding <= expected_symbols.size();
		end
	end

endmodule

// ===== bench/tb_i2c_eeprom_transaction_sequencer.sv =====
`timescale 1ns / 1ps
// Top of the serial EEPROM transaction sequencer bench: clock, reset, requests,
// register writes, symbol back-pressure, watchdog and verdict.
// Depends on iets_pkg, the channel interfaces, the block and iets_symbol_checker.
module tb_i2c_eeprom_transaction_sequencer;

	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 22;
	// unused mode code, handled as a clear
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [iets_pkg::APB_AW-1:0] paddr;
	logic [iets_pkg::APB_DW-1:0] pwdata;
	logic [iets_pkg::APB_DW-1:0] prdata;
	logic                        pready;
	int                          mismatches;
	int                          outstanding;
	int                          idle_cycles = 0;
	int                          phase_requests;
	int                          recv_stall;
	logic                        send_steady;
	logic                        recv_steady;

	iets_req_if req();
	iets_sym_if sym();

	i2c_eeprom_transaction_sequencer dut (
		.clk(clk), .arst_n(arst_n), .req(req), .sym(sym),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	iets_symbol_checker symbol_check (
		.clk(clk), .arst_n(arst_n), .req(req), .sym(sym),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(input logic steady);
		return steady ? 0 : $urandom_range(0, 7);
	endfunction

	// symbol sink: ready held low for a random stall after each accepted symbol
	initial begin
		sym.ready = 1'b0;
		recv_steady = 1'b0;
		recv_stall = $urandom_range(0, 7);
		forever begin
			@(posedge clk);
			if (arst_n && sym.valid && sym.ready) begin
				if ($urandom_range(0, 15) == 0)
					recv_steady = !recv_steady;
				recv_stall = draw_gap(recv_steady);
			end
			@(negedge clk);
			if (recv_stall > 0) begin
				sym.ready <= 1'b0;
				recv_stall--;
			end else begin
				sym.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (sym.valid && sym.ready) || (psel && penable)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("i2c_eeprom_transaction_sequencer: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_request(input logic [1:0] mode, input logic [15:0] address,
			input logic [7:0] data, input logic first, input logic last);
		int gap;
		if ($urandom_range(0, 15) == 0)
			send_steady = !send_steady;
		gap = draw_gap(send_steady);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= mode;
		req.address <= address;
		req.data <= data;
		req.first <= first;
		req.last <= last;
		do @(posedge clk); while (!req.ready);
		phase_requests++;
	endtask

	// drop valid, drain all expected symbols, then give ignored requests time to clear
	task automatic settle();
		@(negedge clk);
		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          phase;
		int          len;
		int          i;
		logic [6:0]  dev;
		logic [15:0] start;
		logic [1:0]  m;
		logic        rd;
		logic        closes;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.mode = iets_pkg::MODE_WRITE;
		req.address = 16'h0000;
		req.data = 8'h00;
		req.first = 1'b0;
		req.last = 1'b0;
		send_steady = 1'b0;
		phase_requests = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// nothing open yet: ignored
		push_request(iets_pkg::MODE_WRITE, 16'h1111, 8'h11, 1'b0, 1'b0);
		push_request(iets_pkg::MODE_WRITE, 16'h003E, 8'h00, 1'b1, 1'b0);
		push_request(iets_pkg::MODE_WRITE, 16'h0000, 8'hFF, 1'b0, 1'b0);
		// reaches 0x0040: page split
		push_request(iets_pkg::MODE_WRITE, 16'hFFFF, 8'h5A, 1'b0, 1'b0);
		push_request(iets_pkg::MODE_CLEAR, 16'h0000, 8'h12, 1'b0, 1'b0);
		push_request(MODE_SPARE, 16'h0000, 8'h34, 1'b0, 1'b1);
		push_request(iets_pkg::MODE_READ, 16'hFFFF, 8'h00, 1'b1, 1'b0);
		// address wraps to zero, reads never split
		push_request(iets_pkg::MODE_READ, 16'h0000, 8'hFF, 1'b0, 1'b0);
		// read to write and back inside one burst
		push_request(iets_pkg::MODE_WRITE, 16'h0000, 8'hC3, 1'b0, 1'b0);
		push_request(iets_pkg::MODE_READ, 16'h0000, 8'h00, 1'b0, 1'b0);
		push_request(iets_pkg::MODE_READ, 16'h0000, 8'h00, 1'b0, 1'b1);
		// first at a page start: header only
		push_request(iets_pkg::MODE_WRITE, 16'h0040, 8'h81, 1'b1, 1'b0);
		// reopen while open: stop first
		push_request(iets_pkg::MODE_WRITE, 16'hFFFE, 8'h7E, 1'b1, 1'b0);
		push_request(iets_pkg::MODE_WRITE, 16'h0000, 8'h01, 1'b0, 1'b0);
		push_request(iets_pkg::MODE_CLEAR, 16'h0000, 8'h00, 1'b0, 1'b0);
		push_request(iets_pkg::MODE_WRITE, 16'hAAAA, 8'hA5, 1'b0, 1'b1);
		push_request(iets_pkg::MODE_WRITE, 16'h5555, 8'h5A, 1'b1, 1'b1);
		push_request(iets_pkg::MODE_READ, 16'h00FF, 8'h00, 1'b1, 1'b1);
		push_request(iets_pkg::MODE_READ, 16'h8000, 8'h00, 1'b1, 1'b0);
		push_request(iets_pkg::MODE_WRITE, 16'h7FFF, 8'h80, 1'b1, 1'b0);
		push_request(iets_pkg::MODE_CLEAR, 16'h0000, 8'h00, 1'b0, 1'b1);
		push_request(iets_pkg::MODE_READ, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
		push_request(MODE_SPARE, 16'hC0C0, 8'h3C, 1'b1, 1'b1);

		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: dev = 7'd0;
				1: dev = 7'd127;
				2: dev = iets_pkg::DEV_ADDR_RESET;
				default: dev = 7'($urandom_range(0, 127));
			endcase
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {iets_pkg::REG_DEVICE_ADDRESS, 2'b00};
			pwdata <= {25'($urandom()), dev};
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;

			phase_requests = 0;
			while (phase_requests < PHASE_REQUESTS) begin
				if ($urandom_range(0, 9) < 7) begin
					len = $urandom_range(1, 8);
					start = 16'($urandom());
					case ($urandom_range(0, 3))
						0: start[5:0] = 6'(64 - $urandom_range(1, 4));
						1: start = 16'hFFFF - 16'($urandom_range(0, 5));
						default: ;
					endcase
					rd = ($urandom_range(0, 2) == 0);
					closes = ($urandom_range(0, 4) != 0);
					for (i = 0; i < len; i++) begin
						// occasional switch between read and write mid-burst
						if (i > 0 && $urandom_range(0, 11) == 0)
							rd = !rd;
						if (rd) begin
							m = iets_pkg::MODE_READ;
						end else begin
							case ($urandom_range(0, 5))
								4: m = iets_pkg::MODE_CLEAR;
								5: m = MODE_SPARE;
								default: m = iets_pkg::MODE_WRITE;
							endcase
						end
						push_request(m, (i == 0) ? start : 16'($urandom()), 8'($urandom()),
							i == 0, closes && i == len - 1);
					end
				end else begin
					repeat ($urandom_range(1, 3))
						push_request(2'($urandom()), 16'($urandom()), 8'($urandom()),
							1'($urandom()), 1'($urandom()));
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("i2c_eeprom_transaction_sequencer: match");
		else
			$display("i2c_eeprom_transaction_sequencer: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
src/iets_pkg.sv
src/iets_if.sv
src/iets_front.sv
src/iets_queue.sv
src/iets_back.sv
src/i2c_eeprom_transaction_sequencer.sv
bench/iets_symbol_checker.sv
bench/tb_i2c_eeprom_transaction_sequencer.sv
